>>> sv/bsmt_pkg.sv
// shared constants, request codes and transaction types for the backing-store map table
// no dependencies
package bsmt_pkg;

  localparam int NUM_STORES       = 8;
  localparam int MAX_PAGES        = 128;
  localparam int PAGE_SHIFT       = 12;
  localparam int FIRST_PAGE_RESET = 4096;

  localparam int ADDR_W   = 32;
  localparam int PAGE_W   = ADDR_W - PAGE_SHIFT;
  localparam int FP_W     = 20;
  localparam int CNT_W    = 8;
  localparam int OWNER_W  = 6;
  localparam int IDXIN_W  = 3;
  localparam int ENTRY_W  = 3;
  localparam int WITHIN_W = 7;
  localparam int IDX_W    = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;
  localparam int DIFF_W   = ((PAGE_W > FP_W) ? PAGE_W : FP_W) + 1;

  localparam int Q_DEPTH = 2;
  localparam int QA_W    = 1;
  localparam int QC_W    = 2;

  typedef logic [1:0] req_t;

  localparam req_t REQ_ALLOC  = 2'd0;
  localparam req_t REQ_FREE   = 2'd1;
  localparam req_t REQ_MAP    = 2'd2;
  localparam req_t REQ_LOOKUP = 2'd3;

  typedef struct packed {
    req_t                req;
    logic                bad;
    logic [IDX_W-1:0]    idx;
    logic [OWNER_W-1:0]  owner;
    logic [FP_W-1:0]     first_page;
    logic [CNT_W-1:0]    count;
    logic [PAGE_W-1:0]   page;
  } cmd_t;

  typedef struct packed {
    logic                failed;
    logic [ENTRY_W-1:0]  entry;
    logic [WITHIN_W-1:0] page_off;
  } res_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [QC_W-1:0] cnt;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic scanning;
  } bk_stat_t;

endpackage

>>> sv/bsmt_front.sv
// front end: accepts request transactions, checks index and page count, forms the page number
// depends on bsmt_pkg
module bsmt_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic [bsmt_pkg::IDXIN_W-1:0] in_entry_index,
  input  logic [bsmt_pkg::OWNER_W-1:0] in_owner,
  input  logic [bsmt_pkg::FP_W-1:0]    in_first_page,
  input  logic [bsmt_pkg::CNT_W-1:0]   in_page_count,
  input  logic [bsmt_pkg::ADDR_W-1:0]  in_virt_addr,
  input  bsmt_pkg::q_stat_t            q_stat,
  output logic                         push,
  output bsmt_pkg::cmd_t               push_cmd
);
  import bsmt_pkg::*;

  logic idx_ok;
  logic cnt_ok;

  always_comb begin
    idx_ok = (int'(in_entry_index) < NUM_STORES);
    cnt_ok = (in_page_count != '0) && (int'(in_page_count) <= MAX_PAGES);

    push_cmd.req        = in_req_type;
    push_cmd.idx        = IDX_W'(in_entry_index);
    push_cmd.owner      = in_owner;
    push_cmd.first_page = in_first_page;
    push_cmd.count      = in_page_count;
    push_cmd.page       = in_virt_addr[ADDR_W-1:PAGE_SHIFT];

    unique case (in_req_type)
      REQ_FREE: push_cmd.bad = !idx_ok;
      REQ_MAP:  push_cmd.bad = !(idx_ok && cnt_ok);
      default:  push_cmd.bad = 1'b0;
    endcase
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

endmodule

>>> sv/bsmt_queue.sv
// short command queue between the front end and the table engine
// depends on bsmt_pkg
module bsmt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bsmt_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output bsmt_pkg::cmd_t    pop_cmd,
  output bsmt_pkg::q_stat_t q_stat
);
  import bsmt_pkg::*;

  cmd_t            slot_r [Q_DEPTH];
  logic [QA_W-1:0] wr_ptr_r;
  logic [QA_W-1:0] rd_ptr_r;
  logic [QC_W-1:0] cnt_r;
  logic [QC_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign pop_cmd      = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QC_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.cnt   = cnt_r;

endmodule

>>> sv/bsmt_back.sv
// table engine: holds the entries, applies free and map, scans one entry a cycle for
// allocate and lookup, and keeps the result register; depends on bsmt_pkg
module bsmt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bsmt_pkg::q_stat_t             q_stat,
  output logic                          pop,
  input  bsmt_pkg::cmd_t                pop_cmd,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_failed,
  output logic [bsmt_pkg::ENTRY_W-1:0]  out_entry_out,
  output logic [bsmt_pkg::WITHIN_W-1:0] out_page_within,
  output bsmt_pkg::bk_stat_t            bk_stat
);
  import bsmt_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                  state_r;
  cmd_t                  cmd_r;
  logic [IDX_W-1:0]      k_r;
  logic [NUM_STORES-1:0] mapped_r;
  logic [OWNER_W-1:0]    owner_r [NUM_STORES];
  logic [FP_W-1:0]       fpage_r [NUM_STORES];
  logic [CNT_W-1:0]      pages_r [NUM_STORES];
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  res_t                  res_r;
  res_t                  res_nxt;

  logic              out_free;
  logic              is_alloc;
  logic              hit;
  logic              last;
  logic              in_rng;
  logic              ok;
  logic [DIFF_W-1:0] diff;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    pop      = (state_r == ST_IDLE) && !q_stat.empty && out_free;
    is_alloc = (cmd_r.req == REQ_ALLOC);
    diff     = DIFF_W'(cmd_r.page) - DIFF_W'(fpage_r[k_r]);
    in_rng   = !diff[DIFF_W-1] && (diff < DIFF_W'(pages_r[k_r]));
    last     = (k_r == IDX_W'(NUM_STORES - 1));
    if (is_alloc) begin
      hit = !mapped_r[k_r];
    end else begin
      hit = mapped_r[k_r] && (owner_r[k_r] == cmd_r.owner);
    end
    ok = hit && (is_alloc || in_rng);

    res_nxt.failed   = !ok;
    res_nxt.entry    = ok ? ENTRY_W'(k_r) : '0;
    res_nxt.page_off = (ok && !is_alloc) ? diff[WITHIN_W-1:0] : '0;
    if (state_r == ST_IDLE) begin
      res_nxt.failed   = pop_cmd.bad;
      res_nxt.entry    = '0;
      res_nxt.page_off = '0;
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (pop && (pop_cmd.req == REQ_FREE || pop_cmd.req == REQ_MAP)) begin
      out_valid_nxt = 1'b1;
    end
    if ((state_r == ST_SCAN) && (hit || last)) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mapped_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            case (pop_cmd.req) inside
              REQ_ALLOC, REQ_LOOKUP: begin
                state_r <= ST_SCAN;
              end
              default: begin
                if (!pop_cmd.bad) begin
                  mapped_r[pop_cmd.idx] <= (pop_cmd.req == REQ_MAP);
                end
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (hit || last) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= pop_cmd;
      k_r   <= '0;
      if (!pop_cmd.bad && pop_cmd.req == REQ_MAP) begin
        owner_r[pop_cmd.idx] <= pop_cmd.owner;
        fpage_r[pop_cmd.idx] <= pop_cmd.first_page;
        pages_r[pop_cmd.idx] <= pop_cmd.count;
      end
      if (!pop_cmd.bad && pop_cmd.req == REQ_FREE) begin
        owner_r[pop_cmd.idx] <= '0;
        fpage_r[pop_cmd.idx] <= FP_W'(FIRST_PAGE_RESET);
        pages_r[pop_cmd.idx] <= '0;
      end
      if (pop_cmd.req == REQ_FREE || pop_cmd.req == REQ_MAP) begin
        res_r <= res_nxt;
      end
    end else if (state_r == ST_SCAN) begin
      if (hit || last) begin
        res_r <= res_nxt;
      end else begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_failed       = res_r.failed;
  assign out_entry_out    = res_r.entry;
  assign out_page_within  = res_r.page_off;
  assign bk_stat.pop      = pop;
  assign bk_stat.scanning = (state_r == ST_SCAN);

endmodule

>>> sv/backing_store_map_table_top.sv
// free and map results pass through the queue slot and the result register; allocate and lookup
// results follow a scan that examines one table entry per cycle
// one free or map per cycle while out_stall is low; no new command is taken during a scan
// reset (synchronous, active low) unmaps every entry and empties the queue, no clearing pass
// depends on bsmt_pkg, bsmt_front, bsmt_queue, bsmt_back
module backing_store_map_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [bsmt_pkg::IDXIN_W-1:0]  in_entry_index,
  input  logic [bsmt_pkg::OWNER_W-1:0]  in_owner,
  input  logic [bsmt_pkg::FP_W-1:0]     in_first_page,
  input  logic [bsmt_pkg::CNT_W-1:0]    in_page_count,
  input  logic [bsmt_pkg::ADDR_W-1:0]   in_virt_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_failed,
  output logic [bsmt_pkg::ENTRY_W-1:0]  out_entry_out,
  output logic [bsmt_pkg::WITHIN_W-1:0] out_page_within
);
  import bsmt_pkg::*;

  logic     push;
  cmd_t     push_cmd;
  logic     pop;
  cmd_t     pop_cmd;
  q_stat_t  q_stat;
  bk_stat_t bk_stat;

  bsmt_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_owner       (in_owner),
    .in_first_page  (in_first_page),
    .in_page_count  (in_page_count),
    .in_virt_addr   (in_virt_addr),
    .q_stat         (q_stat),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  bsmt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  bsmt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop             (pop),
    .pop_cmd         (pop_cmd),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_failed      (out_failed),
    .out_entry_out   (out_entry_out),
    .out_page_within (out_page_within),
    .bk_stat         (bk_stat)
  );

  a_scan_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.scanning |-> !out_valid)
    else $error("result pending during scan");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.cnt <= QC_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_failed) |-> (out_entry_out == '0 && out_page_within == '0))
    else $error("failed transaction carries non-zero fields");

  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_stat.pop || bk_stat.scanning))
    else $error("result without a command in progress");

endmodule
